@@ rtl/rasm_pkg.sv @@
// Shared types and constants for the ratio and symmetry match filter.
// No dependencies; used by every file under rtl.
`timescale 1ns / 1ps

package rasm_pkg;

  // Reverse table geometry and field widths
  localparam int KEY_DEPTH  = 1024;
  localparam int ADDR_W     = $clog2(KEY_DEPTH);
  localparam int IDX_W      = 10;
  localparam int DIST_W     = 24;
  localparam int CNT_W      = 2;
  localparam int RATIO_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = DIST_W + RATIO_W;
  localparam int ENTRY_W    = IDX_W + 1;

  // Stream word layouts
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 1;

  // Register port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd42598;

  typedef enum logic [0:0] {
    REG_RATIO = 1'b0,
    REG_NONE  = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_TEST  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic sweep;
    logic calc;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_code_t in_cmd;
    cmd_code_t item_cmd;
    logic      sweep_last;
    logic      out_free;
  } dp_stat_t;

endpackage

@@ rtl/rasm_ctrl.sv @@
// Sequencer for the match filter: table sweep, read, check, commit and emit steps.
// Depends on rasm_pkg.
`timescale 1ns / 1ps

module rasm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  rasm_pkg::dp_stat_t  stat,
  output rasm_pkg::ctrl_cmd_t cmd
);

  rasm_pkg::state_t state_r;
  rasm_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rasm_pkg::ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      rasm_pkg::ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = rasm_pkg::ST_IDLE;
        end
      end
      rasm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          unique case (stat.in_cmd)
            rasm_pkg::CMD_CLEAR: state_nxt = rasm_pkg::ST_SWEEP;
            rasm_pkg::CMD_LOAD,
            rasm_pkg::CMD_TEST:  state_nxt = rasm_pkg::ST_READ;
            default:             state_nxt = rasm_pkg::ST_IDLE;
          endcase
        end
      end
      rasm_pkg::ST_READ: begin
        cmd.calc  = 1'b1;
        state_nxt = rasm_pkg::ST_CHECK;
      end
      rasm_pkg::ST_CHECK: begin
        if (stat.item_cmd == rasm_pkg::CMD_TEST) begin
          // hold until the output slot is free
          if (stat.out_free) begin
            cmd.emit  = 1'b1;
            state_nxt = rasm_pkg::ST_IDLE;
          end
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = rasm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rasm_pkg::ST_SWEEP;
    endcase
  end

endmodule

@@ rtl/rasm_dpath.sv @@
// Datapath: item registers, ratio multiply-compare, reverse table memory
// and the output word register. Depends on rasm_pkg.
`timescale 1ns / 1ps

module rasm_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rasm_pkg::ctrl_cmd_t                 cmd,
  output rasm_pkg::dp_stat_t                  stat,
  input  logic [rasm_pkg::RATIO_W-1:0]        ratio,
  input  logic [rasm_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [rasm_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rasm_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [rasm_pkg::OUT_USER_W-1:0]     out_tuser
);

  // Unpacked input word
  logic [rasm_pkg::IDX_W-1:0]  in_own;
  logic [rasm_pkg::IDX_W-1:0]  in_best;
  logic [rasm_pkg::DIST_W-1:0] in_near;
  logic [rasm_pkg::DIST_W-1:0] in_second;
  logic [rasm_pkg::CNT_W-1:0]  in_count;

  assign in_own    = in_tdata[9:0];
  assign in_best   = in_tdata[19:10];
  assign in_near   = in_tdata[43:20];
  assign in_second = in_tdata[67:44];
  assign in_count  = in_tdata[69:68];

  // Captured item
  rasm_pkg::cmd_code_t         cmd_r;
  logic [rasm_pkg::IDX_W-1:0]  own_r;
  logic [rasm_pkg::IDX_W-1:0]  best_r;
  logic [rasm_pkg::DIST_W-1:0] near_r;
  logic [rasm_pkg::DIST_W-1:0] second_r;
  logic [rasm_pkg::CNT_W-1:0]  count_r;
  logic [rasm_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r    <= rasm_pkg::cmd_code_t'(in_tuser);
      own_r    <= in_own;
      best_r   <= in_best;
      near_r   <= in_near;
      second_r <= in_second;
      count_r  <= in_count;
    end
    if (cmd.calc) begin
      prod_r <= rasm_pkg::PROD_W'(ratio) * rasm_pkg::PROD_W'(second_r);
    end
  end

  // Ratio test: nearest * 2^16 <= ratio * second, two neighbours needed
  logic [rasm_pkg::PROD_W-1:0] lhs;
  logic                        pass;

  assign lhs  = {near_r, {rasm_pkg::FRAC_W{1'b0}}};
  assign pass = (count_r >= rasm_pkg::CNT_W'(2)) && (lhs <= prod_r);

  // Reverse table: {valid, best}. Valid bits cleared by sweep.
  logic [rasm_pkg::ENTRY_W-1:0] rev_mem [rasm_pkg::KEY_DEPTH];
  logic [rasm_pkg::ENTRY_W-1:0] rd_r;
  logic [rasm_pkg::ADDR_W-1:0]  clr_cnt_r;
  logic [rasm_pkg::ADDR_W-1:0]  clr_cnt_nxt;
  logic                         sweep_last;
  logic                         own_ok;
  logic                         best_ok;

  assign own_ok  = {1'b0, own_r} < (rasm_pkg::IDX_W + 1)'(rasm_pkg::KEY_DEPTH);
  assign best_ok = {1'b0, best_r} < (rasm_pkg::IDX_W + 1)'(rasm_pkg::KEY_DEPTH);

  assign sweep_last = clr_cnt_r == rasm_pkg::ADDR_W'(rasm_pkg::KEY_DEPTH - 1);

  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    if (cmd.sweep) begin
      clr_cnt_nxt = sweep_last ? '0 : clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      rev_mem[clr_cnt_r] <= '0;
    end else if (cmd.commit && (cmd_r == rasm_pkg::CMD_LOAD) && pass && own_ok) begin
      rev_mem[own_r[rasm_pkg::ADDR_W-1:0]] <= {1'b1, best_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_r <= rev_mem[in_best[rasm_pkg::ADDR_W-1:0]];
    end
  end

  // Cross check: reverse entry at best must be valid and point back
  logic hit;
  logic accepted;

  assign hit      = best_ok && rd_r[rasm_pkg::IDX_W]
                    && (rd_r[rasm_pkg::IDX_W-1:0] == own_r);
  assign accepted = pass && hit;

  // Output word register
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  logic [rasm_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic [rasm_pkg::OUT_USER_W-1:0]  out_user_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {4'b0, near_r, best_r, own_r};
      out_user_r <= accepted;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign stat.in_cmd     = rasm_pkg::cmd_code_t'(in_tuser);
  assign stat.item_cmd   = cmd_r;
  assign stat.sweep_last = sweep_last;
  assign stat.out_free   = !out_valid_r || out_tready;

endmodule

@@ rtl/ratio_and_symmetry_match_filter_core.sv @@
// Top level of the ratio and symmetry match filter: register port,
// controller and datapath. Depends on rasm_pkg, rasm_ctrl and rasm_dpath.
// One word is handled at a time. Load and test words pass through accept,
// multiply and check steps; a test word waits in the check step until the
// output register is free. A clear word sweeps the reverse table, one table
// row per cycle. Reset is synchronous; after it a sweep clears the valid bits
// of the reverse table before the first word is taken.
`timescale 1ns / 1ps

module ratio_and_symmetry_match_filter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // own_index[9:0], best_index[19:10], nearest_distance[43:20],
  // second_distance[67:44], neighbour_count[69:68], zero pad [71:70]
  input  logic [rasm_pkg::IN_DATA_W-1:0]    in_tdata,
  // command[1:0]
  input  logic [rasm_pkg::IN_USER_W-1:0]    in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // query_index[9:0], train_index[19:10], match_distance[43:20], zero pad [47:44]
  output logic [rasm_pkg::OUT_DATA_W-1:0]   out_tdata,
  // accepted[0]
  output logic [rasm_pkg::OUT_USER_W-1:0]   out_tuser,
  // register port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [rasm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [rasm_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [rasm_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  // Ratio limit register, Q0.16; one register at byte address 0
  logic [rasm_pkg::RATIO_W-1:0] ratio_r;
  logic [rasm_pkg::RATIO_W-1:0] ratio_nxt;
  rasm_pkg::reg_index_t         reg_sel;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_sel    = rasm_pkg::reg_index_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    ratio_nxt = ratio_r;
    if (cfg_wr && (reg_sel == rasm_pkg::REG_RATIO)) begin
      ratio_nxt = cfg_pwdata[rasm_pkg::RATIO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= rasm_pkg::RATIO_RESET;
    end else begin
      ratio_r <= ratio_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      rasm_pkg::REG_RATIO: cfg_prdata = rasm_pkg::CFG_DATA_W'(ratio_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // Controller and datapath
  rasm_pkg::ctrl_cmd_t ctrl_cmd;
  rasm_pkg::dp_stat_t  dp_stat;

  rasm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (dp_stat),
    .cmd       (ctrl_cmd)
  );

  rasm_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ctrl_cmd),
    .stat       (dp_stat),
    .ratio      (ratio_r),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ tb/rasm_match_checker.sv @@
// Scoreboard for the ratio and symmetry match filter: watches the input, result and
// register ports, keeps its own copy of the reverse table and compares every result.
// Depends on rasm_pkg.
`timescale 1ns / 1ps

module rasm_match_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [rasm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [rasm_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [rasm_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [rasm_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [rasm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [rasm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                            cfg_pready,
  output int                              fail_count,
  output int                              pending,
  output int                              tests_seen,
  output int                              hits_seen
);

  typedef struct packed {
    logic                        accepted;
    logic [rasm_pkg::IDX_W-1:0]  query;
    logic [rasm_pkg::IDX_W-1:0]  train;
    logic [rasm_pkg::DIST_W-1:0] distance;
  } match_verdict_t;

  logic [rasm_pkg::RATIO_W-1:0] ratio_q;
  bit                           rev_valid [rasm_pkg::KEY_DEPTH];
  logic [rasm_pkg::IDX_W-1:0]   rev_best  [rasm_pkg::KEY_DEPTH];
  match_verdict_t               verdict_q [$];

  // nearest/second <= ratio, done as an exact product compare
  function automatic bit ratio_passes(logic [rasm_pkg::DIST_W-1:0] nearest,
                                      logic [rasm_pkg::DIST_W-1:0] second,
                                      logic [rasm_pkg::CNT_W-1:0]  count);
    logic [rasm_pkg::PROD_W-1:0] lhs;
    logic [rasm_pkg::PROD_W-1:0] rhs;
    lhs = {nearest, {rasm_pkg::FRAC_W{1'b0}}};
    rhs = rasm_pkg::PROD_W'(ratio_q) * rasm_pkg::PROD_W'(second);
    return (count >= 2) && (lhs <= rhs);
  endfunction

  always @(posedge clk) begin : watch
    int                          fail_n;
    int                          test_n;
    int                          hit_n;
    match_verdict_t              got;
    match_verdict_t              want;
    rasm_pkg::cmd_code_t         cmd;
    logic [rasm_pkg::IDX_W-1:0]  own;
    logic [rasm_pkg::IDX_W-1:0]  best;
    logic [rasm_pkg::DIST_W-1:0] nearest;
    logic [rasm_pkg::DIST_W-1:0] second;
    logic [rasm_pkg::CNT_W-1:0]  count;
    bit                          ok;

    if (!rst_n) begin
      ratio_q   = rasm_pkg::RATIO_RESET;
      rev_valid = '{default: 1'b0};
      verdict_q.delete();
      fail_n = 0;
      test_n = 0;
      hit_n  = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          rasm_pkg::reg_index_t'(cfg_paddr[2]) == rasm_pkg::REG_RATIO)
        ratio_q = cfg_pwdata[rasm_pkg::RATIO_W-1:0];

      // results first: a word taken on this edge cannot have its result yet
      if (out_tvalid && out_tready) begin
        got.accepted = out_tuser[0];
        got.query    = out_tdata[rasm_pkg::IDX_W-1:0];
        got.train    = out_tdata[2*rasm_pkg::IDX_W-1:rasm_pkg::IDX_W];
        got.distance = out_tdata[2*rasm_pkg::IDX_W+rasm_pkg::DIST_W-1:2*rasm_pkg::IDX_W];
        if (got.accepted === 1'b1)
          hit_n++;
        if (verdict_q.size() == 0) begin
          fail_n++;
          if (fail_n <= 10)
            $display("%t: result word with nothing expected: acc %b q %0d t %0d d %h",
                     $realtime, got.accepted, got.query, got.train, got.distance);
        end else begin
          want = verdict_q.pop_front();
          if (got.accepted !== want.accepted || got.query !== want.query ||
              got.train !== want.train || got.distance !== want.distance) begin
            fail_n++;
            if (fail_n <= 10)
              $display({"%t: result mismatch: expected acc %b q %0d t %0d d %h, ",
                        "got acc %b q %0d t %0d d %h"},
                       $realtime, want.accepted, want.query, want.train, want.distance,
                       got.accepted, got.query, got.train, got.distance);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        cmd     = rasm_pkg::cmd_code_t'(in_tuser[1:0]);
        own     = in_tdata[rasm_pkg::IDX_W-1:0];
        best    = in_tdata[2*rasm_pkg::IDX_W-1:rasm_pkg::IDX_W];
        nearest = in_tdata[2*rasm_pkg::IDX_W+rasm_pkg::DIST_W-1:2*rasm_pkg::IDX_W];
        second  = in_tdata[2*rasm_pkg::IDX_W+2*rasm_pkg::DIST_W-1:
                           2*rasm_pkg::IDX_W+rasm_pkg::DIST_W];
        count   = in_tdata[2*rasm_pkg::IDX_W+2*rasm_pkg::DIST_W+rasm_pkg::CNT_W-1:
                           2*rasm_pkg::IDX_W+2*rasm_pkg::DIST_W];
        case (cmd)
          rasm_pkg::CMD_CLEAR: rev_valid = '{default: 1'b0};
          rasm_pkg::CMD_LOAD: begin
            if (int'(own) < rasm_pkg::KEY_DEPTH && ratio_passes(nearest, second, count)) begin
              rev_valid[own] = 1'b1;
              rev_best[own]  = best;
            end
          end
          rasm_pkg::CMD_TEST: begin
            ok = ratio_passes(nearest, second, count);
            if (ok)
              ok = int'(best) < rasm_pkg::KEY_DEPTH && rev_valid[best] &&
                   rev_best[best] == own;
            want.accepted = ok;
            want.query    = own;
            want.train    = best;
            want.distance = nearest;
            verdict_q.insert(verdict_q.size(), want);
            test_n++;
          end
          default: ;  // unused command: no effect
        endcase
      end
    end
    fail_count <= fail_n;
    pending    <= verdict_q.size();
    tests_seen <= test_n;
    hits_seen  <= hit_n;
  end

endmodule

@@ tb/ratio_and_symmetry_match_filter_core_tb.sv @@
// Testbench top for ratio_and_symmetry_match_filter_core: clock, reset, stimulus,
// register writes, result back-pressure and the verdict. Depends on rasm_pkg,
// the core and rasm_match_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module ratio_and_symmetry_match_filter_core_tb;

  // Cycles with no word taken before the run is declared hung. A clear holds
  // off the input while it sweeps the reverse table, and so does the sweep after
  // reset, so this leaves several times the worst legitimate quiet stretch.
  localparam int HANG_LIMIT  = 6000;
  localparam int RAND_WORDS  = 1750;
  localparam int NUM_PHASES  = 5;
  localparam int ROUND_MAX   = 24;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [rasm_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [rasm_pkg::IN_USER_W-1:0]  in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [rasm_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [rasm_pkg::OUT_USER_W-1:0] out_tuser;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [rasm_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [rasm_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [rasm_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  int fail_count;
  int pending;
  int tests_seen;
  int hits_seen;

  // stimulus bookkeeping (not prediction: only used to steer distances)
  logic [rasm_pkg::RATIO_W-1:0] cur_ratio;
  int words_sent;
  int burst_left;
  int idle_cycles;

  ratio_and_symmetry_match_filter_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  rasm_match_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending),
    .tests_seen  (tests_seen),
    .hits_seen   (hits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any handshake on either stream or a register access counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready))
      idle_cycles <= 0;
    else if (idle_cycles >= HANG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d results outstanding",
               HANG_LIMIT, pending);
      $display("** ratio_and_symmetry_match_filter_core: FAILED **");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Gap length before a word: mostly none or short, now and then long,
  // with occasional bursts of back-to-back words.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result-side back-pressure: ready runs broken by stalls, plus long stall-free stretches.
  initial begin : sink
    int r;
    @(posedge rst_n);
    forever begin
      r = $urandom_range(0, 99);
      out_tready <= 1'b1;
      if (r < 8)
        repeat ($urandom_range(50, 200)) @(posedge clk);
      else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_tready <= 1'b0;
        if (r < 70)      repeat ($urandom_range(1, 3)) @(posedge clk);
        else if (r < 96) repeat ($urandom_range(4, 10)) @(posedge clk);
        else             repeat ($urandom_range(20, 40)) @(posedge clk);
      end
    end
  end

  // One input word; returns just after the edge that took it.
  task automatic send_word(rasm_pkg::cmd_code_t cmd,
                           logic [rasm_pkg::IDX_W-1:0] own,
                           logic [rasm_pkg::IDX_W-1:0] best,
                           logic [rasm_pkg::DIST_W-1:0] nearest,
                           logic [rasm_pkg::DIST_W-1:0] second,
                           logic [rasm_pkg::CNT_W-1:0] count);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, count, second, nearest, best, own};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (cmd != rasm_pkg::CMD_NONE)
      words_sent++;
  endtask

  // Setup then access phase; register written at the access edge.
  task automatic write_ratio(logic [rasm_pkg::RATIO_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= rasm_pkg::CFG_ADDR_W'(4 * int'(rasm_pkg::REG_RATIO));
    cfg_pwdata  <= {{(rasm_pkg::CFG_DATA_W-rasm_pkg::RATIO_W){1'b0}}, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cur_ratio = value;
  endtask

  // Wait for every result, then let a load still in flight settle.
  // The checker's count is registered, so look only after the next edge.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Distance pair: most near the ratio boundary or below it, so both
  // outcomes of the ratio test turn up often.
  task automatic pick_dists(output logic [rasm_pkg::DIST_W-1:0] nearest,
                            output logic [rasm_pkg::DIST_W-1:0] second);
    int r;
    logic [rasm_pkg::PROD_W-1:0] prod;
    logic [rasm_pkg::DIST_W:0]   edge_pt;
    r = $urandom_range(0, 99);
    if (r < 70)      second = rasm_pkg::DIST_W'($urandom);
    else if (r < 85) second = rasm_pkg::DIST_W'($urandom_range(0, 255));
    else if (r < 93) second = '0;
    else             second = '1;
    prod    = rasm_pkg::PROD_W'(cur_ratio) * rasm_pkg::PROD_W'(second);
    edge_pt = (rasm_pkg::DIST_W+1)'(prod >> rasm_pkg::FRAC_W);
    r = $urandom_range(0, 99);
    if (r < 40) begin
      // exactly on the boundary, one above or one below
      edge_pt = edge_pt + (rasm_pkg::DIST_W+1)'($urandom_range(0, 2)) - 1;
      if (edge_pt[rasm_pkg::DIST_W])
        edge_pt = (r < 20) ? '0 : {1'b0, {rasm_pkg::DIST_W{1'b1}}};
      nearest = edge_pt[rasm_pkg::DIST_W-1:0];
    end else if (r < 75)
      nearest = rasm_pkg::DIST_W'({8'd0, $urandom} % ({8'd0, edge_pt} + 1));
    else
      nearest = rasm_pkg::DIST_W'($urandom);
  endtask

  function automatic logic [rasm_pkg::CNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 2'd2;
    if (r < 90) return 2'd3;
    if (r < 95) return 2'd1;
    return 2'd0;
  endfunction

  // Anything at all: wrong commands, random indices, random distances.
  task automatic send_noise();
    int r;
    rasm_pkg::cmd_code_t cmd;
    r = $urandom_range(0, 99);
    if (r < 2)       cmd = rasm_pkg::CMD_CLEAR;
    else if (r < 40) cmd = rasm_pkg::CMD_LOAD;
    else if (r < 80) cmd = rasm_pkg::CMD_TEST;
    else             cmd = rasm_pkg::CMD_NONE;
    send_word(cmd, rasm_pkg::IDX_W'($urandom), rasm_pkg::IDX_W'($urandom),
              rasm_pkg::DIST_W'($urandom), rasm_pkg::DIST_W'($urandom),
              rasm_pkg::CNT_W'($urandom));
  endtask

  // A well-formed round: optional clear, reverse loads for a set of pairs,
  // then the forward tests of those pairs in shuffled order, with noise mixed in.
  task automatic run_round();
    logic [rasm_pkg::IDX_W-1:0]  qry [ROUND_MAX];
    logic [rasm_pkg::IDX_W-1:0]  trn [ROUND_MAX];
    logic [rasm_pkg::IDX_W-1:0]  tmp;
    logic [rasm_pkg::DIST_W-1:0] nearest;
    logic [rasm_pkg::DIST_W-1:0] second;
    int n;
    int j;
    n = $urandom_range(4, ROUND_MAX);
    if ($urandom_range(0, 2) == 0)
      send_word(rasm_pkg::CMD_CLEAR, rasm_pkg::IDX_W'($urandom), rasm_pkg::IDX_W'($urandom),
                rasm_pkg::DIST_W'($urandom), rasm_pkg::DIST_W'($urandom),
                rasm_pkg::CNT_W'($urandom));
    for (int i = 0; i < n; i++) begin
      qry[i] = rasm_pkg::IDX_W'($urandom);
      trn[i] = rasm_pkg::IDX_W'($urandom);
    end
    for (int i = 0; i < n; i++) begin
      pick_dists(nearest, second);
      send_word(rasm_pkg::CMD_LOAD, trn[i],
                ($urandom_range(0, 9) == 0) ? rasm_pkg::IDX_W'($urandom) : qry[i],
                nearest, second, pick_count());
      if ($urandom_range(0, 9) == 0) send_noise();
    end
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = qry[i]; qry[i] = qry[j]; qry[j] = tmp;
      tmp = trn[i]; trn[i] = trn[j]; trn[j] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      pick_dists(nearest, second);
      send_word(rasm_pkg::CMD_TEST,
                ($urandom_range(0, 9) == 0) ? rasm_pkg::IDX_W'($urandom) : qry[i], trn[i],
                nearest, second, pick_count());
      if ($urandom_range(0, 9) == 0) send_noise();
    end
  endtask

  initial begin : stim
    logic [rasm_pkg::RATIO_W-1:0] ratios [NUM_PHASES];
    int phase_goal;
    int total;

    // every input known from time zero
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = rasm_pkg::CMD_NONE;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    cur_ratio   = rasm_pkg::RATIO_RESET;
    words_sent  = 0;
    burst_left  = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part, at the reset ratio (0.65) ----
    // empty table: a passing ratio alone is not enough
    send_word(rasm_pkg::CMD_TEST, 10'd5, 10'd7, 24'd0, 24'd100, 2'd2);
    // reverse 7 -> 5, then the cross-checked forward 5 -> 7
    send_word(rasm_pkg::CMD_LOAD, 10'd7, 10'd5, 24'h000100, 24'h000200, 2'd2);
    send_word(rasm_pkg::CMD_TEST, 10'd5, 10'd7, 24'd1, 24'd2, 2'd2);
    // reverse entry points elsewhere: rejected but fields still carried
    send_word(rasm_pkg::CMD_TEST, 10'd6, 10'd7, 24'd1, 24'd2, 2'd2);
    // too few neighbours
    send_word(rasm_pkg::CMD_TEST, 10'd5, 10'd7, 24'd1, 24'd2, 2'd1);
    send_word(rasm_pkg::CMD_TEST, 10'd5, 10'd7, 24'd1, 24'd2, 2'd0);
    // a count of three acts as two
    send_word(rasm_pkg::CMD_TEST, 10'd5, 10'd7, 24'd1, 24'd2, 2'd3);
    // zero second distance: 0/0 passes, anything else over 0 fails
    send_word(rasm_pkg::CMD_LOAD, 10'd1023, 10'd0, 24'd0, 24'd0, 2'd2);
    send_word(rasm_pkg::CMD_TEST, 10'd0, 10'd1023, 24'd0, 24'd0, 2'd2);
    send_word(rasm_pkg::CMD_TEST, 10'd0, 10'd1023, 24'd1, 24'd0, 2'd2);
    // repeated load: passing one wins, failing one leaves the entry alone
    send_word(rasm_pkg::CMD_LOAD, 10'd7, 10'd9, 24'd10, 24'd100, 2'd3);
    send_word(rasm_pkg::CMD_LOAD, 10'd7, 10'd5, 24'd100, 24'd100, 2'd2);
    send_word(rasm_pkg::CMD_TEST, 10'd9, 10'd7, 24'd3, 24'd5, 2'd2);
    send_word(rasm_pkg::CMD_TEST, 10'd5, 10'd7, 24'd3, 24'd5, 2'd2);
    // unused command must not touch the table
    send_word(rasm_pkg::CMD_NONE, 10'd7, 10'd5, 24'd0, 24'hFFFFFF, 2'd2);
    send_word(rasm_pkg::CMD_TEST, 10'd9, 10'd7, 24'd0, 24'hFFFFFF, 2'd2);
    // distance extremes
    send_word(rasm_pkg::CMD_LOAD, 10'd0, 10'd1023, 24'hFFFFFF, 24'hFFFFFF, 2'd2);
    send_word(rasm_pkg::CMD_TEST, 10'd1023, 10'd0, 24'hFFFFFF, 24'hFFFFFF, 2'd2);
    send_word(rasm_pkg::CMD_TEST, 10'd1023, 10'd0, 24'd0, 24'hFFFFFF, 2'd2);
    // clear wipes everything
    send_word(rasm_pkg::CMD_CLEAR, 10'h3FF, 10'h3FF, 24'hFFFFFF, 24'hFFFFFF, 2'd3);
    send_word(rasm_pkg::CMD_TEST, 10'd9, 10'd7, 24'd0, 24'hFFFFFF, 2'd2);
    send_word(rasm_pkg::CMD_TEST, 10'd0, 10'd1023, 24'd0, 24'd0, 2'd2);
    wait_drained();

    // ---- random part, one phase per ratio setting, extremes included ----
    ratios[0] = '0;
    ratios[1] = '1;
    ratios[2] = rasm_pkg::RATIO_W'($urandom);
    ratios[3] = 16'h8000;
    ratios[4] = rasm_pkg::RATIO_RESET;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_ratio(ratios[p]);
      phase_goal = words_sent + RAND_WORDS / NUM_PHASES;
      while (words_sent < phase_goal)
        run_round();
      // end each phase on a test, so a drained result queue means an idle block
      send_word(rasm_pkg::CMD_TEST, rasm_pkg::IDX_W'($urandom), rasm_pkg::IDX_W'($urandom),
                rasm_pkg::DIST_W'($urandom), rasm_pkg::DIST_W'($urandom), 2'd2);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    total = fail_count + pending;
    $display("run covered %0d input words and %0d forward tests (%0d accepted)",
             words_sent, tests_seen, hits_seen);
    $display("at the reset ratio and %0d programmed ones; mismatches: %0d, never delivered: %0d",
             NUM_PHASES, fail_count, pending);
    if (total == 0)
      $display("** ratio_and_symmetry_match_filter_core: PASSED **");
    else
      $display("** ratio_and_symmetry_match_filter_core: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rasm_pkg.sv
rtl/rasm_ctrl.sv
rtl/rasm_dpath.sv
rtl/ratio_and_symmetry_match_filter_core.sv
tb/rasm_match_checker.sv
tb/ratio_and_symmetry_match_filter_core_tb.sv
